// ===== rtl/akf_pkg.sv =====
// Shared types, widths, constants and saturation helpers for the angle Kalman filter.
`timescale 1ns / 1ps

package akf_pkg;

	// Fixed point format of state, gains and fields.
	localparam int FRAC_BITS = 16;

	// Field widths
	localparam int ACCEL_W     = 25;
	localparam int GYRO_W      = 28;
	localparam int ANGLE_OUT_W = 25;
	localparam int RATE_OUT_W  = 29;
	localparam int BIAS_OUT_W  = 28;

	// Configuration register widths
	localparam int Q_W  = 16;
	localparam int R_W  = 25;
	localparam int DT_W = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 25;

	localparam logic [CFG_IDX_W-1:0] REG_Q_ANGLE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_Q_GYRO    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_R_ANGLE   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = CFG_IDX_W'(3);

	localparam logic [Q_W-1:0]  Q_ANGLE_RST   = Q_W'(66);
	localparam logic [Q_W-1:0]  Q_GYRO_RST    = Q_W'(197);
	localparam logic [R_W-1:0]  R_ANGLE_RST   = R_W'(32768);
	localparam logic [DT_W-1:0] STEP_TIME_RST = DT_W'(328);

	// Datapath widths
	localparam int STATE_W = 32;
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 2;

	// Divider
	localparam int DEN_W     = 33;
	localparam int DIV_STEPS = STATE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
	localparam logic signed [STATE_W-1:0] ONE_Q     = STATE_W'(64'd1 << FRAC_BITS);
	localparam logic signed [PROD_W-1:0]  ROUND_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

	// Output ranges
	localparam logic signed [ACC_W-1:0] ANGLE_LIM = ACC_W'(11796480);
	localparam logic signed [ACC_W-1:0] RATE_LIM  = ACC_W'(262144000);
	localparam logic signed [ACC_W-1:0] BIAS_LIM  = ACC_W'(131072000);

	typedef struct packed {
		logic                        start;
		logic signed [STATE_W-1:0]   num;
		logic        [DEN_W-1:0]     den;
	} div_req_t;

	typedef struct packed {
		logic                        done;
		logic signed [STATE_W-1:0]   quot;
	} div_rsp_t;

	// Clamp a wide signed value to the signed state range.
	function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		if ((&v[ACC_W-1:STATE_W-1]) || (~|v[ACC_W-1:STATE_W-1])) begin
			return v[STATE_W-1:0];
		end else if (v[ACC_W-1]) begin
			return STATE_MIN;
		end else begin
			return STATE_MAX;
		end
	endfunction

	// Clamp a wide signed value to +-lim.
	function automatic logic signed [ACC_W-1:0] sat_lim(input logic signed [ACC_W-1:0] v,
		input logic signed [ACC_W-1:0] lim);
		if (v > lim) begin
			return lim;
		end else if (v < -lim) begin
			return -lim;
		end else begin
			return v;
		end
	endfunction

endpackage

// ===== rtl/akf_in_if.sv =====
// Input channel: one accelerometer angle and one gyro rate per transaction.
`timescale 1ns / 1ps

interface akf_in_if import akf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ACCEL_W-1:0] tilt_angle;
	logic signed [GYRO_W-1:0]  gyro_rate;

	modport source (output valid, output tilt_angle, output gyro_rate, input ready);
	modport sink   (input valid, input tilt_angle, input gyro_rate, output ready);
endinterface

// ===== rtl/akf_out_if.sv =====
// Result channel: angle, corrected rate and bias per transaction.
`timescale 1ns / 1ps

interface akf_out_if import akf_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_OUT_W-1:0] angle_estimate;
	logic signed [RATE_OUT_W-1:0]  rate_estimate;
	logic signed [BIAS_OUT_W-1:0]  bias_estimate;

	modport source (output valid, output angle_estimate, output rate_estimate,
		output bias_estimate, input ready);
	modport sink   (input valid, input angle_estimate, input rate_estimate,
		input bias_estimate, output ready);
endinterface

// ===== rtl/akf_cfg_if.sv =====
// Configuration write channel: register index and write data per transaction.
`timescale 1ns / 1ps

interface akf_cfg_if import akf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/angle_kalman_filter.sv =====
// Top level of the angle Kalman filter: sequencer, state, shared multiplier and output register.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// sample    in   valid / ready      tilt_angle[24:0], gyro_rate[27:0]    (signed Q16.16)
// result    out  valid / ready      angle_estimate[24:0], rate_estimate[28:0],
//                                   bias_estimate[27:0]                  (signed Q16.16)
// cfg       in   valid / ready      index[3:0], data[24:0]; ready is always high
//
// From acceptance to the next ready, an item runs ten multiply operations through one
// shared 34x32 multiplier, plus two gain divisions in the bit-serial divider. When
// the innovation variance is not positive the divisions are skipped.
// Reset loads the register defaults, zero angle and bias, and the identity covariance.
// A result waits in the output register; the next item is taken meanwhile and holds
// at its end only if the earlier result is still not taken.

module angle_kalman_filter import akf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	akf_in_if.sink    sample,
	akf_out_if.source result,
	akf_cfg_if.sink   cfg
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE = ST_W'(0);
	localparam logic [ST_W-1:0] ST_LOAD = ST_W'(1);
	localparam logic [ST_W-1:0] ST_MUL  = ST_W'(2);
	localparam logic [ST_W-1:0] ST_ACC  = ST_W'(3);
	localparam logic [ST_W-1:0] ST_PREP = ST_W'(4);
	localparam logic [ST_W-1:0] ST_GAIN = ST_W'(5);
	localparam logic [ST_W-1:0] ST_DIV0 = ST_W'(6);
	localparam logic [ST_W-1:0] ST_DIV1 = ST_W'(7);
	localparam logic [ST_W-1:0] ST_OUT  = ST_W'(8);

	// Multiply operations, in issue order. Prediction first, then the
	// covariance correction (P10 and P11 before P00 and P01 so that each
	// reads the predicted value), then the state correction.
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_ANGLE_PRED = OP_W'(0);
	localparam logic [OP_W-1:0] OP_P00_PRED   = OP_W'(1);
	localparam logic [OP_W-1:0] OP_PX1_PRED   = OP_W'(2);
	localparam logic [OP_W-1:0] OP_P11_PRED   = OP_W'(3);
	localparam logic [OP_W-1:0] OP_P10_CORR   = OP_W'(4);
	localparam logic [OP_W-1:0] OP_P11_CORR   = OP_W'(5);
	localparam logic [OP_W-1:0] OP_P00_CORR   = OP_W'(6);
	localparam logic [OP_W-1:0] OP_P01_CORR   = OP_W'(7);
	localparam logic [OP_W-1:0] OP_ANGLE_CORR = OP_W'(8);
	localparam logic [OP_W-1:0] OP_BIAS_CORR  = OP_W'(9);

	// Sequencer
	logic [ST_W-1:0] state_q;
	logic [OP_W-1:0] op_q;

	// Configuration registers
	logic [Q_W-1:0]  q_angle_q;
	logic [Q_W-1:0]  q_gyro_q;
	logic [R_W-1:0]  r_angle_q;
	logic [DT_W-1:0] step_time_q;

	// Filter state
	logic signed [STATE_W-1:0] angle_q;
	logic signed [STATE_W-1:0] bias_q;
	logic signed [STATE_W-1:0] p00_q;
	logic signed [STATE_W-1:0] p01_q;
	logic signed [STATE_W-1:0] p10_q;
	logic signed [STATE_W-1:0] p11_q;

	// Per-item working registers
	logic signed [ACCEL_W-1:0] accel_q;
	logic signed [GYRO_W-1:0]  gyro_q;
	logic signed [STATE_W-1:0] err_q;
	logic [DEN_W-1:0]          e_q;
	logic                      epos_q;
	logic signed [STATE_W-1:0] k0_q;
	logic signed [STATE_W-1:0] k1_q;

	// Shared multiplier
	logic signed [MUL_A_W-1:0] opa_q;
	logic signed [MUL_B_W-1:0] opb_q;
	logic signed [PROD_W-1:0]  prod_q;

	// Output register
	logic                          out_valid_q;
	logic signed [ANGLE_OUT_W-1:0] angle_out_q;
	logic signed [RATE_OUT_W-1:0]  rate_out_q;
	logic signed [BIAS_OUT_W-1:0]  bias_out_q;

	logic                      in_fire;
	logic                      out_load;
	logic [OP_W-1:0]           op_sel;
	logic signed [MUL_A_W-1:0] opa_d;
	logic signed [MUL_B_W-1:0] opb_d;
	logic signed [MUL_A_W-1:0] gyro_a;
	logic signed [MUL_A_W-1:0] bias_a;
	logic signed [MUL_A_W-1:0] p01_a;
	logic signed [MUL_A_W-1:0] p10_a;
	logic signed [MUL_B_W-1:0] dt_b;

	logic signed [PROD_W-1:0]  prod_rnd;
	logic signed [PROD_W-1:0]  rnd;
	logic signed [ACC_W-1:0]   rnd_ext;
	logic signed [STATE_W-1:0] acc_base;
	logic                      acc_sub;
	logic signed [ACC_W-1:0]   acc_base_ext;
	logic signed [ACC_W-1:0]   acc_sum;
	logic signed [STATE_W-1:0] acc_val;
	logic signed [ACC_W-1:0]   p10_sum;
	logic signed [STATE_W-1:0] p10_val;

	logic signed [ACC_W-1:0]   angle_ext;
	logic signed [ACC_W-1:0]   bias_ext;
	logic signed [ACC_W-1:0]   accel_ext;
	logic signed [ACC_W-1:0]   gyro_ext;
	logic signed [ACC_W-1:0]   err_wide;
	logic signed [ACC_W-1:0]   e_wide;
	logic signed [ACC_W-1:0]   angle_sat;
	logic signed [ACC_W-1:0]   rate_sat;
	logic signed [ACC_W-1:0]   bias_sat;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign in_fire   = sample.valid && sample.ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q   <= Q_ANGLE_RST;
			q_gyro_q    <= Q_GYRO_RST;
			r_angle_q   <= R_ANGLE_RST;
			step_time_q <= STEP_TIME_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_Q_ANGLE:   q_angle_q   <= cfg.data[Q_W-1:0];
				REG_Q_GYRO:    q_gyro_q    <= cfg.data[Q_W-1:0];
				REG_R_ANGLE:   r_angle_q   <= cfg.data[R_W-1:0];
				REG_STEP_TIME: step_time_q <= cfg.data[DT_W-1:0];
				default: ;
			endcase
		end
	end

	// Operand select. In ST_ACC the next operation's operands are loaded
	// alongside the write-back: no operation reads what its predecessor writes.
	assign op_sel = (state_q == ST_ACC) ? (op_q + OP_W'(1)) : op_q;

	assign gyro_a = {{(MUL_A_W-GYRO_W){gyro_q[GYRO_W-1]}}, gyro_q};
	assign bias_a = {{(MUL_A_W-STATE_W){bias_q[STATE_W-1]}}, bias_q};
	assign p01_a  = {{(MUL_A_W-STATE_W){p01_q[STATE_W-1]}}, p01_q};
	assign p10_a  = {{(MUL_A_W-STATE_W){p10_q[STATE_W-1]}}, p10_q};
	assign dt_b   = {{(MUL_B_W-DT_W){1'b0}}, step_time_q};

	always_comb begin
		opa_d = '0;
		opb_d = '0;
		case (op_sel)
			OP_ANGLE_PRED: begin
				opa_d = gyro_a - bias_a;
				opb_d = dt_b;
			end
			OP_P00_PRED: begin
				opa_d = {{(MUL_A_W-Q_W){1'b0}}, q_angle_q} - p01_a - p10_a;
				opb_d = dt_b;
			end
			OP_PX1_PRED: begin
				opa_d = {{(MUL_A_W-STATE_W){p11_q[STATE_W-1]}}, p11_q};
				opb_d = dt_b;
			end
			OP_P11_PRED: begin
				opa_d = {{(MUL_A_W-Q_W){1'b0}}, q_gyro_q};
				opb_d = dt_b;
			end
			OP_P10_CORR: begin
				opa_d = {{(MUL_A_W-STATE_W){p00_q[STATE_W-1]}}, p00_q};
				opb_d = k1_q;
			end
			OP_P11_CORR: begin
				opa_d = p01_a;
				opb_d = k1_q;
			end
			OP_P00_CORR: begin
				opa_d = {{(MUL_A_W-STATE_W){p00_q[STATE_W-1]}}, p00_q};
				opb_d = k0_q;
			end
			OP_P01_CORR: begin
				opa_d = p01_a;
				opb_d = k0_q;
			end
			OP_ANGLE_CORR: begin
				opa_d = {{(MUL_A_W-STATE_W){err_q[STATE_W-1]}}, err_q};
				opb_d = k0_q;
			end
			OP_BIAS_CORR: begin
				opa_d = {{(MUL_A_W-STATE_W){err_q[STATE_W-1]}}, err_q};
				opb_d = k1_q;
			end
			default: ;
		endcase
	end

	// Round half up, then add to or subtract from the destination and clamp.
	assign prod_rnd = prod_q + ROUND_HALF;
	assign rnd      = prod_rnd >>> FRAC_BITS;
	assign rnd_ext  = {{(ACC_W-PROD_W){rnd[PROD_W-1]}}, rnd};

	always_comb begin
		acc_base = angle_q;
		acc_sub  = 1'b0;
		case (op_q)
			OP_ANGLE_PRED: begin
				acc_base = angle_q;
				acc_sub  = 1'b0;
			end
			OP_P00_PRED: begin
				acc_base = p00_q;
				acc_sub  = 1'b0;
			end
			OP_PX1_PRED: begin
				acc_base = p01_q;
				acc_sub  = 1'b1;
			end
			OP_P11_PRED: begin
				acc_base = p11_q;
				acc_sub  = 1'b0;
			end
			OP_P10_CORR: begin
				acc_base = p10_q;
				acc_sub  = 1'b1;
			end
			OP_P11_CORR: begin
				acc_base = p11_q;
				acc_sub  = 1'b1;
			end
			OP_P00_CORR: begin
				acc_base = p00_q;
				acc_sub  = 1'b1;
			end
			OP_P01_CORR: begin
				acc_base = p01_q;
				acc_sub  = 1'b1;
			end
			OP_ANGLE_CORR: begin
				acc_base = angle_q;
				acc_sub  = 1'b0;
			end
			OP_BIAS_CORR: begin
				acc_base = bias_q;
				acc_sub  = 1'b0;
			end
			default: ;
		endcase
	end

	assign acc_base_ext = {{(ACC_W-STATE_W){acc_base[STATE_W-1]}}, acc_base};
	assign acc_sum      = acc_sub ? (acc_base_ext - rnd_ext) : (acc_base_ext + rnd_ext);
	assign acc_val      = sat32(acc_sum);

	// P10 shares the P11*dt product with P01 during prediction.
	assign p10_sum = {{(ACC_W-STATE_W){p10_q[STATE_W-1]}}, p10_q} - rnd_ext;
	assign p10_val = sat32(p10_sum);

	// Innovation, its variance, and the output clamps.
	assign angle_ext = {{(ACC_W-STATE_W){angle_q[STATE_W-1]}}, angle_q};
	assign bias_ext  = {{(ACC_W-STATE_W){bias_q[STATE_W-1]}}, bias_q};
	assign accel_ext = {{(ACC_W-ACCEL_W){accel_q[ACCEL_W-1]}}, accel_q};
	assign gyro_ext  = {{(ACC_W-GYRO_W){gyro_q[GYRO_W-1]}}, gyro_q};
	assign err_wide  = accel_ext - angle_ext;
	assign e_wide    = {{(ACC_W-R_W){1'b0}}, r_angle_q}
		+ {{(ACC_W-STATE_W){p00_q[STATE_W-1]}}, p00_q};

	assign angle_sat = sat_lim(angle_ext, ANGLE_LIM);
	assign rate_sat  = sat_lim(gyro_ext - bias_ext, RATE_LIM);
	assign bias_sat  = sat_lim(bias_ext, BIAS_LIM);

	// Gains: K0 = P00 / E first, then K1 = P10 / E.
	assign div_req.start = ((state_q == ST_GAIN) && epos_q)
		|| ((state_q == ST_DIV0) && div_rsp.done);
	assign div_req.num   = (state_q == ST_GAIN) ? p00_q : p10_q;
	assign div_req.den   = e_q;

	akf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_ANGLE_PRED;
			angle_q <= '0;
			bias_q  <= '0;
			p00_q   <= ONE_Q;
			p01_q   <= '0;
			p10_q   <= '0;
			p11_q   <= ONE_Q;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q    <= OP_ANGLE_PRED;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					case (op_q)
						OP_ANGLE_PRED: angle_q <= acc_val;
						OP_P00_PRED:   p00_q   <= acc_val;
						OP_PX1_PRED: begin
							p01_q <= acc_val;
							p10_q <= p10_val;
						end
						OP_P11_PRED:   p11_q   <= acc_val;
						OP_P10_CORR:   p10_q   <= acc_val;
						OP_P11_CORR:   p11_q   <= acc_val;
						OP_P00_CORR:   p00_q   <= acc_val;
						OP_P01_CORR:   p01_q   <= acc_val;
						OP_ANGLE_CORR: angle_q <= acc_val;
						OP_BIAS_CORR:  bias_q  <= acc_val;
						default: ;
					endcase
					if (op_q == OP_P11_PRED) begin
						state_q <= ST_PREP;
					end else if (op_q == OP_BIAS_CORR) begin
						state_q <= ST_OUT;
					end else begin
						op_q    <= op_q + OP_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_PREP: begin
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					if (epos_q) begin
						state_q <= ST_DIV0;
					end else begin
						op_q    <= OP_P10_CORR;
						state_q <= ST_LOAD;
					end
				end
				ST_DIV0: begin
					if (div_rsp.done) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						op_q    <= OP_P10_CORR;
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			accel_q <= sample.tilt_angle;
			gyro_q  <= sample.gyro_rate;
		end
		if ((state_q == ST_LOAD) || (state_q == ST_ACC)) begin
			opa_q <= opa_d;
			opb_q <= opb_d;
		end
		if (state_q == ST_MUL) begin
			prod_q <= opa_q * opb_q;
		end
		if (state_q == ST_PREP) begin
			err_q  <= sat32(err_wide);
			e_q    <= e_wide[DEN_W-1:0];
			epos_q <= !e_wide[ACC_W-1] && (e_wide != '0);
		end
		if ((state_q == ST_GAIN) && !epos_q) begin
			k0_q <= '0;
			k1_q <= '0;
		end
		if ((state_q == ST_DIV0) && div_rsp.done) begin
			k0_q <= div_rsp.quot;
		end
		if ((state_q == ST_DIV1) && div_rsp.done) begin
			k1_q <= div_rsp.quot;
		end
		if (out_load) begin
			angle_out_q <= angle_sat[ANGLE_OUT_W-1:0];
			rate_out_q  <= rate_sat[RATE_OUT_W-1:0];
			bias_out_q  <= bias_sat[BIAS_OUT_W-1:0];
		end
	end

	// Output register: hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.angle_estimate = angle_out_q;
	assign result.rate_estimate  = rate_out_q;
	assign result.bias_estimate  = bias_out_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !sample.ready)
		else $error("second item taken while one is in work");

	a_div_pos: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> epos_q)
		else $error("gain division started with a non-positive variance");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV0) || (state_q == ST_DIV1))
		else $error("divider finished outside a gain state");

endmodule

// ===== rtl/akf_div.sv =====
// Radix-2 restoring divider producing a saturated signed Q gain, one quotient bit per cycle.
`timescale 1ns / 1ps

module akf_div import akf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                       busy_q;
	logic                       done_q;
	logic [DIV_CNT_W-1:0]       cnt_q;
	logic [DEN_W-1:0]           den_q;
	logic [DEN_W-1:0]           rem_q;
	logic [STATE_W-1:0]         quo_q;
	logic                       ovf_q;
	logic                       neg_q;

	logic [STATE_W-1:0]         mag;
	logic [STATE_W+FRAC_BITS-1:0] num_ext;
	logic [DEN_W-1:0]           num_hi;
	logic                       start_ovf;
	logic [DEN_W:0]             shifted;
	logic                       ge;
	logic [DEN_W:0]             diff;
	logic signed [STATE_W-1:0]  quot;

	// Scale |num| by 2^FRAC_BITS; the part above the low quotient word must stay below den.
	assign mag       = req.num[STATE_W-1] ? (~req.num + STATE_W'(1)) : req.num;
	assign num_ext   = {mag, {FRAC_BITS{1'b0}}};
	assign num_hi    = {{(DEN_W-FRAC_BITS){1'b0}}, num_ext[STATE_W+FRAC_BITS-1:STATE_W]};
	assign start_ovf = (num_hi >= req.den);

	assign shifted = {rem_q, quo_q[STATE_W-1]};
	assign ge      = (shifted >= {1'b0, den_q});
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			ovf_q <= start_ovf;
			neg_q <= req.num[STATE_W-1];
			rem_q <= start_ovf ? '0 : num_hi;
			quo_q <= num_ext[STATE_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[STATE_W-2:0], ge};
		end
	end

	// Apply sign and clamp to the signed state range.
	always_comb begin
		if (ovf_q) begin
			quot = neg_q ? STATE_MIN : STATE_MAX;
		end else if (neg_q) begin
			quot = (quo_q > STATE_MIN) ? STATE_MIN : (~quo_q + STATE_W'(1));
		end else begin
			quot = quo_q[STATE_W-1] ? STATE_MAX : quo_q;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a finished run");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(req.start))
		else $error("divider busy without a start");

endmodule

// ===== tb/sv/angle_kalman_filter_test.sv =====
// Self-checking testbench of the angle Kalman filter: sensor samples checked against a fixed-point predictor.
`timescale 1ns / 1ps

module angle_kalman_filter_test;
	import akf_pkg::*;

	// Nominal input ranges (Q16.16): +-180 degrees and +-2000 degrees per second
	localparam longint ACCEL_LIM = 11796480;
	localparam longint GYRO_LIM  = 131072000;
	localparam longint ONE_Q16   = longint'(1) << FRAC_BITS;

	// Register indexes that decode to nothing; writes there must leave the filter alone
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_STEP_TIME + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

	typedef struct {
		logic signed [ACCEL_W-1:0] accel;
		logic signed [GYRO_W-1:0]  gyro;
	} sample_t;

	typedef struct {
		logic signed [ANGLE_OUT_W-1:0] angle;
		logic signed [RATE_OUT_W-1:0]  rate;
		logic signed [BIAS_OUT_W-1:0]  bias;
	} estimate_t;

	typedef enum {STALL_NONE, STALL_SHORT, STALL_LONG} stall_mode_e;

	logic clk;
	logic arst_n;

	akf_in_if  sample_if ();
	akf_out_if result_if ();
	akf_cfg_if cfg_if ();

	angle_kalman_filter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// Samples waiting for the input channel, and estimates waiting for the result channel
	sample_t   pending_samples[$];
	estimate_t predicted_estimates[$];
	estimate_t want;

	// Predictor copy of the filter state and its registers (state held saturated to 32 bits)
	longint angle_st, bias_st;
	longint cov [4];
	longint q_angle_reg, q_gyro_reg, r_angle_reg, step_time_reg;

	// Slowly moving tilt scenario that drives the well-formed part of the random stimulus
	longint trk_angle, trk_rate, trk_bias;

	int updates_done, results_seen, reg_writes, no_gain_updates, clipped_results, mismatches;
	int burst_left, gap_left, stall_left, pattern_left;
	stall_mode_e stall_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit: far above the slowest legal run, so only a hung handshake reaches it
	initial begin
		#40_000_000;
		$display("Timeout with %0d samples and %0d estimates still outstanding",
			pending_samples.size(), predicted_estimates.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Fixed-point predictor
	// ------------------------------------------------------------------

	function automatic longint clamp_state(input longint v);
		if (v > longint'(STATE_MAX)) return longint'(STATE_MAX);
		if (v < longint'(STATE_MIN)) return longint'(STATE_MIN);
		return v;
	endfunction

	function automatic longint clamp_range(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Q16.16 product, rounded half up (the arithmetic shift floors)
	function automatic longint qmul(input longint a, input longint b);
		return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic void reset_filter_model();
		q_angle_reg   = longint'(Q_ANGLE_RST);
		q_gyro_reg    = longint'(Q_GYRO_RST);
		r_angle_reg   = longint'(R_ANGLE_RST);
		step_time_reg = longint'(STEP_TIME_RST);
		angle_st      = 0;
		bias_st       = 0;
		cov[0]        = ONE_Q16;
		cov[1]        = 0;
		cov[2]        = 0;
		cov[3]        = ONE_Q16;
	endfunction

	// Advance the model by one sample and queue the estimate the block must return for it
	function automatic void kalman_update(input sample_t s);
		longint accel, gyro, dt, p00, p01, p10, p11, err, innov, k0, k1, rate;
		estimate_t est;
		accel = s.accel;
		gyro  = s.gyro;
		dt    = step_time_reg;

		// Predict: integrate the bias-corrected rate, grow the covariance
		angle_st = clamp_state(angle_st + qmul(gyro - bias_st, dt));
		p00 = clamp_state(cov[0] + qmul(q_angle_reg - cov[1] - cov[2], dt));
		p01 = clamp_state(cov[1] - qmul(cov[3], dt));
		p10 = clamp_state(cov[2] - qmul(cov[3], dt));
		p11 = clamp_state(cov[3] + qmul(q_gyro_reg, dt));

		// Gains; a non-positive innovation variance zeroes both gains, so the correction changes nothing
		err   = clamp_state(accel - angle_st);
		innov = r_angle_reg + p00;
		if (innov > 0) begin
			k0 = clamp_state((p00 * ONE_Q16) / innov);
			k1 = clamp_state((p10 * ONE_Q16) / innov);
		end else begin
			k0 = 0;
			k1 = 0;
			no_gain_updates++;
		end

		// Correct covariance from the predicted terms, then angle and bias
		cov[0]   = clamp_state(p00 - qmul(k0, p00));
		cov[1]   = clamp_state(p01 - qmul(k0, p01));
		cov[2]   = clamp_state(p10 - qmul(k1, p00));
		cov[3]   = clamp_state(p11 - qmul(k1, p01));
		angle_st = clamp_state(angle_st + qmul(k0, err));
		bias_st  = clamp_state(bias_st + qmul(k1, err));
		rate     = gyro - bias_st;

		est.angle = ANGLE_OUT_W'(clamp_range(angle_st, longint'(ANGLE_LIM)));
		est.rate  = RATE_OUT_W'(clamp_range(rate, longint'(RATE_LIM)));
		est.bias  = BIAS_OUT_W'(clamp_range(bias_st, longint'(BIAS_LIM)));
		if (angle_st != clamp_range(angle_st, longint'(ANGLE_LIM)) ||
			rate != clamp_range(rate, longint'(RATE_LIM)) ||
			bias_st != clamp_range(bias_st, longint'(BIAS_LIM))) begin
			clipped_results++;
		end
		predicted_estimates.push_back(est);
		updates_done++;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Uniform value in [-lim, lim]
	function automatic longint spread(input longint lim);
		return longint'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// Queue one sample; the values wrap to the field widths
	function automatic void push_sample(input longint a, input longint g);
		sample_t s;
		s.accel = ACCEL_W'(a);
		s.gyro  = GYRO_W'(g);
		pending_samples.push_back(s);
	endfunction

	// Mostly a coherent tilt scenario with sensor noise, plus in-range and raw noise samples
	function automatic sample_t random_sample();
		sample_t s;
		int unsigned pick;
		longint a, g;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			trk_rate  = clamp_range(trk_rate + spread(1310720), 13107200);
			trk_angle = clamp_range(trk_angle + trk_rate / 100, ACCEL_LIM);
			a = trk_angle + spread(131072);
			g = trk_rate + trk_bias + spread(32768);
		end else if (pick < 90) begin
			a = spread(ACCEL_LIM);
			g = spread(GYRO_LIM);
		end else begin
			a = longint'($urandom);
			g = longint'($urandom);
		end
		s.accel = ACCEL_W'(a);
		s.gyro  = GYRO_W'(g);
		return s;
	endfunction

	task automatic wait_drained();
		while (pending_samples.size() != 0 || predicted_estimates.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// One register transaction on the configuration channel
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] qa, input logic [CFG_DATA_W-1:0] qg,
		input logic [CFG_DATA_W-1:0] ra, input logic [CFG_DATA_W-1:0] dt);
		write_reg(REG_Q_ANGLE, qa);
		write_reg(REG_Q_GYRO, qg);
		write_reg(REG_R_ANGLE, ra);
		write_reg(REG_STEP_TIME, dt);
	endtask

	// Random samples in two halves; the sender holds off between them until the block is empty
	task automatic run_random(input int count);
		trk_angle = spread(ACCEL_LIM / 2);
		trk_rate  = 0;
		trk_bias  = spread(327680);
		for (int i = 0; i < count / 2; i++) pending_samples.push_back(random_sample());
		wait_drained();
		for (int i = count / 2; i < count; i++) pending_samples.push_back(random_sample());
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Sample driver: bursts of random length separated by random gaps
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_if.valid      <= 1'b0;
			sample_if.tilt_angle <= '0;
			sample_if.gyro_rate  <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			// A transaction completed at this edge: predict it and retire it
			if (sample_if.valid && sample_if.ready) begin
				kalman_update(pending_samples[0]);
				pending_samples.delete(0);
			end

			if (sample_if.valid && !sample_if.ready) begin
				// Hold the offered sample until the block takes it
			end else if (gap_left > 0) begin
				gap_left--;
				sample_if.valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				sample_if.valid      <= 1'b1;
				sample_if.tilt_angle <= pending_samples[0].accel;
				sample_if.gyro_rate  <= pending_samples[0].gyro;
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					// New burst; a third of them follow on with no gap at all
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 100);
				end
			end else begin
				sample_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor and receiver stall pattern
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left   = 0;
			pattern_left = 0;
			stall_mode   = STALL_NONE;
		end else begin
			if (result_if.valid && result_if.ready) begin
				results_seen++;
				if (predicted_estimates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unsolicited estimate angle=%0d rate=%0d bias=%0d", $time,
							result_if.angle_estimate, result_if.rate_estimate,
							result_if.bias_estimate);
					end
				end else begin
					want = predicted_estimates.pop_front();
					if (result_if.angle_estimate !== want.angle ||
						result_if.rate_estimate !== want.rate ||
						result_if.bias_estimate !== want.bias) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: estimate %0d expected angle=%0d rate=%0d bias=%0d",
								$time, results_seen, want.angle, want.rate, want.bias);
							$display("%0t: estimate %0d actual   angle=%0d rate=%0d bias=%0d",
								$time, results_seen, result_if.angle_estimate,
								result_if.rate_estimate, result_if.bias_estimate);
						end
					end
				end
			end

			// Switch between no stalls, frequent short stalls and rare long ones
			if (pattern_left <= 0) begin
				stall_mode   = stall_mode_e'($urandom_range(0, 2));
				pattern_left = $urandom_range(200, 2000);
			end
			pattern_left--;

			if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				case (stall_mode)
					STALL_SHORT: begin
						if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 4);
					end
					STALL_LONG: begin
						if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(20, 150);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Mirror every accepted register transaction into the predictor; spare indexes drop out
	always @(posedge clk) begin
		if (arst_n && cfg_if.valid && cfg_if.ready) begin
			reg_writes++;
			case (cfg_if.index)
				REG_Q_ANGLE:   q_angle_reg   = longint'(cfg_if.data[Q_W-1:0]);
				REG_Q_GYRO:    q_gyro_reg    = longint'(cfg_if.data[Q_W-1:0]);
				REG_R_ANGLE:   r_angle_reg   = longint'(cfg_if.data[R_W-1:0]);
				REG_STEP_TIME: step_time_reg = longint'(cfg_if.data[DT_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		reset_filter_model();
		cfg_if.valid          = 1'b0;
		cfg_if.index          = '0;
		cfg_if.data           = '0;
		arst_n                = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: field corners, raw extremes beyond the nominal ranges, bit patterns
		push_sample(0, 0);
		push_sample(ACCEL_LIM, 0);
		push_sample(-ACCEL_LIM, 0);
		push_sample(0, GYRO_LIM);
		push_sample(0, -GYRO_LIM);
		push_sample(ACCEL_LIM, GYRO_LIM);
		push_sample(-ACCEL_LIM, -GYRO_LIM);
		push_sample(ACCEL_LIM, -GYRO_LIM);
		push_sample({1'b0, {(ACCEL_W-1){1'b1}}}, {1'b0, {(GYRO_W-1){1'b1}}});
		push_sample({1'b1, {(ACCEL_W-1){1'b0}}}, {1'b1, {(GYRO_W-1){1'b0}}});
		push_sample(1, 1);
		push_sample(-1, -1);
		push_sample(25'h0AAAAAA, 28'h5555555);
		push_sample(25'h1555555, 28'hAAAAAAA);
		run_random(300);

		// Maximum noise, minimum measurement noise, largest step just under one second: drive the
		// state into saturation with full-scale rates; the q_angle write also carries upper data bits
		set_config('1, 16'hFFFF, 1, 16'hFFFF);
		repeat (6) push_sample(ACCEL_LIM, GYRO_LIM);
		repeat (4) push_sample({1'b1, {(ACCEL_W-1){1'b0}}}, {1'b1, {(GYRO_W-1){1'b0}}});
		run_random(150);

		// No process noise and no measurement noise: the innovation variance collapses
		// to zero or below, and the correction must then be skipped
		set_config(0, 0, 0, STEP_TIME_RST);
		write_reg(REG_SPARE_FIRST, '1);
		write_reg(REG_SPARE_LAST, 25'h0000ABC);
		run_random(120);

		// Largest measurement noise with a zero step: prediction is a no-op
		set_config(1, 1, '1, 0);
		run_random(100);

		// Nominal top of the measurement noise range with the shortest nonzero step
		set_config(16'hFFFF, 0, 25'h1000000, 1);
		run_random(100);

		// Assorted settings: mostly plausible, now and then raw register values
		repeat (6) begin
			if ($urandom_range(0, 3) == 0) begin
				set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
			end else begin
				set_config(CFG_DATA_W'($urandom_range(0, 2000)),
					CFG_DATA_W'($urandom_range(0, 2000)),
					CFG_DATA_W'($urandom_range(1, 1 << 20)),
					CFG_DATA_W'($urandom_range(1, 3000)));
			end
			run_random(150);
		end

		// Back to the reset settings
		set_config(Q_ANGLE_RST, Q_GYRO_RST, R_ANGLE_RST, STEP_TIME_RST);
		run_random(200);

		// Let the pipeline settle; anything that shows up now is unsolicited
		wait_drained();
		repeat (100) @(posedge clk);
		mismatches += predicted_estimates.size();

		$display("Run covered %0d filter updates and %0d register transactions.",
			updates_done, reg_writes);
		$display("%0d updates ran with zero gain, %0d estimates were clipped to a field range.",
			no_gain_updates, clipped_results);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d estimate errors", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== angle_kalman_filter.f =====
rtl/akf_pkg.sv
rtl/akf_in_if.sv
rtl/akf_out_if.sv
rtl/akf_cfg_if.sv
rtl/akf_div.sv
rtl/angle_kalman_filter.sv
tb/sv/angle_kalman_filter_test.sv
